@@ design/pffsa_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pffsa_pkg
// Types and constants for the paged first-fit slot allocator.
// ============================================================================
package pffsa_pkg;

    localparam int TOTAL_SLOTS = 1024;
    localparam int WORD_W      = 32;                    // flags per memory row
    localparam int NUM_WORDS   = TOTAL_SLOTS / WORD_W;
    localparam int WORD_AW     = $clog2(NUM_WORDS);
    localparam int BIT_AW      = $clog2(WORD_W);
    localparam int SLOT_AW     = $clog2(TOTAL_SLOTS);
    localparam int CNT_W       = SLOT_AW + 1;           // holds 0..TOTAL_SLOTS
    localparam int PAGE_W      = 11;                    // page_slots / open_pages
    localparam int MAX_PAGE    = 1024;
    localparam int PS_RESET    = 64;
    localparam logic [15:0] NONE_INDEX = 16'hFFFF;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_WAS_FREE = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type   req_type;
        logic [15:0] slot_index;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [9:0]          granted_index;
        logic [PAGE_W-1:0]   open_pages;
        logic                all_free;
    } t_res;

endpackage

@@ design/pffsa_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pffsa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pffsa_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/paged_first_fit_slot_allocator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// paged_first_fit_slot_allocator
// First-fit slot allocator over a paged taken/free flag store held in RAM.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  -----------------------
//  request   in         i_in_valid / o_in_stall     i_in_data  (t_req)
//  result    out        o_out_valid / i_out_stall   o_out_data (t_res)
//  config    in         i_cfg_we (write only)       i_cfg_wdata (page_slots)
//
//  Steps: accept + row read, modify + write back, result hand-off; the
//  flag RAM returns its read data from a register.
//  Reset: i_rst_n synchronous; row valid bits and full bits clear at once,
//  so no clearing pass is needed. A page_slots write clears them likewise.
//  Stalls: a result waits in the output register; a new request is taken
//  meanwhile, and it finishes once that register drains.
//
// Flags live in NUM_WORDS rows of WORD_W bits. Per row, a valid bit (row
// reads as all free until first written) and a full bit (all WORD_W taken).
// The first non-full row, found from the full bits, holds the lowest free
// slot. Taken slots always lie below the open length, so that slot is either
// inside the open pages or exactly the first slot of the next page.
// ============================================================================
module paged_first_fit_slot_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  pffsa_pkg::t_req           i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output pffsa_pkg::t_res           o_out_data,
    input  logic                      i_cfg_we,
    input  logic [pffsa_pkg::PAGE_W-1:0] i_cfg_wdata
);
    import pffsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state               r_state, n_state;
    t_req                 r_req;
    logic [WORD_AW-1:0]   r_word;
    logic                 r_have;          // a non-full row existed at accept
    logic [NUM_WORDS-1:0] r_row_vld;
    logic [NUM_WORDS-1:0] r_full;
    logic [CNT_W-1:0]     r_taken_cnt, n_taken_cnt;
    logic [CNT_W-1:0]     r_open_len,  n_open_len;   // pages * page size
    logic [PAGE_W-1:0]    r_pages,     n_pages;
    logic [CNT_W-1:0]     r_ps;                      // effective page size
    t_res                 r_pend, n_pend;
    logic                 r_out_valid;
    t_res                 r_out;

    // ---- accept side: pick the row to read ----
    logic               in_acc;
    logic [WORD_AW-1:0] free_word;
    logic               have_free;
    logic [WORD_AW-1:0] rd_addr;

    assign in_acc = i_in_valid && !o_in_stall;

    always_comb begin
        free_word = '0;
        have_free = 1'b0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                free_word = WORD_AW'(i);
                have_free = 1'b1;
            end
        end
    end

    assign rd_addr = (i_in_data.req_type == REQ_ALLOC) ? free_word
                   : i_in_data.slot_index[SLOT_AW-1:BIT_AW];

    // ---- flag RAM ----
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    pffsa_ram #(
        .P_WIDTH (WORD_W),
        .P_DEPTH (NUM_WORDS)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // ---- modify stage ----
    logic [WORD_W-1:0]  word_q;
    logic [BIT_AW-1:0]  zero_bit;
    logic [BIT_AW-1:0]  bit_sel;
    logic [WORD_W-1:0]  bit_mask;
    logic [SLOT_AW-1:0] grant;
    logic [CNT_W:0]     open_sum;
    logic               room;
    logic               is_alloc;
    logic               alloc_ok;
    logic               grows;
    logic               rel_none;
    logic               rel_range;
    logic               rel_ok;
    t_status            status;

    assign word_q = r_row_vld[r_word] ? ram_rdata : '0;

    always_comb begin
        zero_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word_q[i]) begin
                zero_bit = BIT_AW'(i);
            end
        end
    end

    assign is_alloc = (r_req.req_type == REQ_ALLOC);
    assign bit_sel  = is_alloc ? zero_bit : r_req.slot_index[BIT_AW-1:0];
    assign bit_mask = WORD_W'(1) << bit_sel;
    assign grant    = {r_word, zero_bit};
    assign open_sum = {1'b0, r_open_len} + {1'b0, r_ps};
    assign room     = (open_sum <= (CNT_W + 1)'(TOTAL_SLOTS));

    // first free slot past the open pages can only be the next page's first
    assign grows     = r_have && ({1'b0, grant} >= r_open_len) && room;
    assign alloc_ok  = r_have && (({1'b0, grant} < r_open_len) || room);
    assign rel_none  = (r_req.slot_index == NONE_INDEX);
    assign rel_range = (r_req.slot_index >= 16'(r_open_len));
    assign rel_ok    = !rel_none && !rel_range && word_q[bit_sel];

    always_comb begin
        if (is_alloc) begin
            status = alloc_ok ? ST_OK : ST_FULL;
        end else if (rel_none) begin
            status = ST_OK;
        end else if (rel_range) begin
            status = ST_RANGE;
        end else if (!word_q[bit_sel]) begin
            status = ST_WAS_FREE;
        end else begin
            status = ST_OK;
        end
    end

    assign ram_we    = (r_state == S_MOD) && (is_alloc ? alloc_ok : rel_ok);
    assign ram_wdata = is_alloc ? (word_q | bit_mask) : (word_q & ~bit_mask);

    always_comb begin
        n_taken_cnt = r_taken_cnt;
        n_open_len  = r_open_len;
        n_pages     = r_pages;
        if (is_alloc && alloc_ok) begin
            n_taken_cnt = r_taken_cnt + CNT_W'(1);
        end else if (!is_alloc && rel_ok) begin
            n_taken_cnt = r_taken_cnt - CNT_W'(1);
        end
        if (is_alloc && grows) begin
            n_open_len = open_sum[CNT_W-1:0];
            n_pages    = r_pages + PAGE_W'(1);
        end
        n_pend.status        = status;
        n_pend.granted_index = (is_alloc && alloc_ok) ? grant : '0;
        n_pend.open_pages    = n_pages;
        n_pend.all_free      = (n_taken_cnt == '0);
    end

    // ---- sequencer ----
    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_MOD;
            S_MOD:   n_state = S_WAIT;
            S_WAIT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // effective page size of a configuration write
    logic [CNT_W-1:0] cfg_ps;
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_ps = CNT_W'(1);
        end else if (i_cfg_wdata > PAGE_W'(MAX_PAGE)) begin
            cfg_ps = CNT_W'(MAX_PAGE);
        end else begin
            cfg_ps = CNT_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_vld   <= '0;
            r_full      <= '0;
            r_taken_cnt <= '0;
            r_ps        <= CNT_W'(PS_RESET);
            r_open_len  <= CNT_W'(PS_RESET);
            r_pages     <= PAGE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MOD) begin
                r_taken_cnt <= n_taken_cnt;
                r_open_len  <= n_open_len;
                r_pages     <= n_pages;
                if (ram_we) begin
                    r_row_vld[r_word] <= 1'b1;
                    r_full[r_word]    <= &ram_wdata;
                end
            end
            if (r_state == S_WAIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_ps        <= cfg_ps;
                r_open_len  <= cfg_ps;
                r_pages     <= PAGE_W'(1);
                r_row_vld   <= '0;
                r_full      <= '0;
                r_taken_cnt <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= i_in_data;
            r_word <= rd_addr;
            r_have <= have_free;
        end
        if (r_state == S_MOD) begin
            r_pend <= n_pend;
        end
        if (r_state == S_WAIT && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- assertions ----
    a_taken_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken_cnt <= r_open_len)
        else $error("taken count exceeds open length");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_len <= CNT_W'(TOTAL_SLOTS))
        else $error("open length beyond store");

    a_full_has_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full & ~r_row_vld) == '0)
        else $error("full row without valid bit");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && is_alloc && alloc_ok && !i_cfg_we)
        |=> r_taken_cnt == $past(r_taken_cnt) + CNT_W'(1))
        else $error("allocate did not bump taken count");

    a_grant_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && is_alloc && alloc_ok)
        |-> ({1'b0, grant} < n_open_len))
        else $error("grant outside open pages");

endmodule
